@@ sv/source_text_tokenizer_defines.svh @@
// Assertion macros shared by the source text tokenizer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define STT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tokenizer assertion failed");

// Next-cycle implication, checked outside reset.
`define STT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tokenizer assertion failed");

`endif

@@ sv/stt_pkg.sv @@
// Shared types and constants of the source text tokenizer.
// Depends on nothing; imported by every tokenizer module.
package stt_pkg;

   // Position counter width and the width of positions on the result port.
   localparam int POS_BITS     = 24;
   localparam int OUT_POS_BITS = 24;

   // Token queue between the classifier and the output stage.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [POS_BITS-1:0]     pos_type;
   typedef logic [OUT_POS_BITS-1:0] out_pos_type;
   typedef logic [QPTR_W-1:0]       qptr_type;
   typedef logic [QCNT_W-1:0]       qcnt_type;

   // Token kind codes, in result-port numbering.
   typedef enum logic [5:0] {
      TK_FUN, TK_STRUCT, TK_UNSAVE, TK_WHERE, TK_PRINT, TK_ENUM, TK_NAME, TK_ARROW,
      TK_LPAREN, TK_RPAREN, TK_COLON, TK_SEMI, TK_PLUS, TK_MINUS, TK_STAR, TK_SLASH,
      TK_PERCENT, TK_HASH, TK_DOLLAR, TK_AT, TK_DOT, TK_DOTDOT, TK_LT, TK_GT,
      TK_ASSIGN, TK_EQ, TK_LE, TK_GE, TK_OROR, TK_ANDAND, TK_BAR, TK_AMP,
      TK_LBRACE, TK_RBRACE, TK_LBRACKET, TK_RBRACKET, TK_NEWLINE, TK_COMMENT_OPEN,
      TK_COMMENT_CLOSE
   } token_kind_type;

   // One finished token.
   typedef struct packed {
      token_kind_type kind;
      out_pos_type    first_pos;
      out_pos_type    final_pos;
      logic           last;
   } token_type;

   // Tokens produced by one accepted transaction (zero, one or two).
   typedef struct packed {
      logic [1:0] count;
      token_type  tok0;
      token_type  tok1;
   } push_type;

   // Queue fill status seen by both sides.
   typedef struct packed {
      qcnt_type count;
      logic     not_empty;
   } qstat_type;

endpackage

@@ sv/source_text_tokenizer.sv @@
// The tokenizer takes one source byte per cycle while req_stall is low (or an end-of-text
// mark) and returns tokens as a kind code with first and last byte positions; last_of_run
// flags the final token of each input transaction. The classifier accepts a new byte every
// cycle while the token queue has room for two tokens; the output register delivers one
// token per cycle while rsp_stall is low, and the four-entry queue absorbs a byte that
// releases two tokens (a name or lookahead operator followed by punctuation). Tokens pass
// from the queue through the result register to the result port. Operator bytes are held
// until the next byte or the end mark decides between their one- and two-byte forms.
// Depends on stt_pkg, stt_front, stt_token_queue, stt_back and the assertion macro header.
`include "source_text_tokenizer_defines.svh"

module source_text_tokenizer (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_source_byte,
   input  logic                              req_end_of_text,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [5:0]                        rsp_token_kind,
   output logic [stt_pkg::OUT_POS_BITS-1:0]  rsp_first_pos,
   output logic [stt_pkg::OUT_POS_BITS-1:0]  rsp_final_pos,
   output logic                              rsp_last_of_run
);
   import stt_pkg::*;

   push_type  push;
   qstat_type q_stat;
   token_type head;
   logic      q_pop;

   // Classifier and lookahead state.
   stt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_source_byte (req_source_byte),
      .req_end_of_text (req_end_of_text),
      .q_stat          (q_stat),
      .push            (push)
   );

   // Decoupling queue.
   stt_token_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop    (q_pop),
      .head   (head),
      .q_stat (q_stat)
   );

   // Result register.
   stt_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_stat          (q_stat),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_first_pos   (rsp_first_pos),
      .rsp_final_pos   (rsp_final_pos),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // The queue never holds more tokens than it has entries.
   `STT_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, q_stat.count <= qcnt_type'(QUEUE_DEPTH))
   // The output stage only pops a queue that holds a token.
   `STT_ASSERT_NOW(a_no_underflow, clock, reset, q_pop, q_stat.not_empty)
   // Tokens pushed by a transaction are visible in the queue or on the result port next cycle.
   `STT_ASSERT_NEXT(a_push_visible, clock, reset, push.count != 2'd0, q_stat.not_empty || rsp_valid)

endmodule

@@ sv/stt_front.sv @@
// Front end of the tokenizer: classifies each byte, keeps the lookahead and name state.
// Depends on stt_pkg; feeds stt_token_queue.
module stt_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_source_byte,
   input  logic               req_end_of_text,
   input  stt_pkg::qstat_type q_stat,
   output stt_pkg::push_type  push
);
   import stt_pkg::*;

   // Operator held for one byte of lookahead.
   typedef enum logic [3:0] {
      OP_NONE, OP_LT, OP_GT, OP_MINUS, OP_STAR, OP_SLASH, OP_AMP, OP_BAR, OP_EQ, OP_DOT
   } held_op_type;

   typedef struct packed {
      logic           valid;
      token_kind_type kind;
   } punct_type;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_DOLL  = 8'h24;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_PCT   = 8'h25;

   // Keyword texts, first byte in the low bits, unused bytes zero.
   localparam logic [47:0] KW_FUN    = 48'h0000006E7566;
   localparam logic [47:0] KW_STRUCT = 48'h746375727473;
   localparam logic [47:0] KW_UNSAVE = 48'h657661736E75;
   localparam logic [47:0] KW_WHERE  = 48'h006572656877;
   localparam logic [47:0] KW_ENUM   = 48'h00006D756E65;
   localparam logic [47:0] KW_PRINT  = 48'h00746E697270;

   localparam logic [2:0] NAME_KEEP = 3'd6;
   localparam logic [2:0] NAME_SAT  = 3'd7;

   function automatic held_op_type op_of(input logic [7:0] c);
      held_op_type r;
      unique case (c)
         8'h3C:   r = OP_LT;
         8'h3E:   r = OP_GT;
         8'h2D:   r = OP_MINUS;
         8'h2A:   r = OP_STAR;
         8'h2F:   r = OP_SLASH;
         8'h26:   r = OP_AMP;
         8'h7C:   r = OP_BAR;
         8'h3D:   r = OP_EQ;
         8'h2E:   r = OP_DOT;
         default: r = OP_NONE;
      endcase
      return r;
   endfunction

   function automatic punct_type punct_of(input logic [7:0] c);
      punct_type r;
      r.valid = 1'b1;
      unique case (c)
         8'h29:   r.kind = TK_RPAREN;
         8'h28:   r.kind = TK_LPAREN;
         8'h3A:   r.kind = TK_COLON;
         8'h3B:   r.kind = TK_SEMI;
         CH_LF:   r.kind = TK_NEWLINE;
         8'h7B:   r.kind = TK_LBRACE;
         8'h7D:   r.kind = TK_RBRACE;
         8'h5B:   r.kind = TK_LBRACKET;
         8'h5D:   r.kind = TK_RBRACKET;
         8'h2B:   r.kind = TK_PLUS;
         CH_PCT:  r.kind = TK_PERCENT;
         CH_HASH: r.kind = TK_HASH;
         CH_DOLL: r.kind = TK_DOLLAR;
         CH_AT:   r.kind = TK_AT;
         default: begin
            r.valid = 1'b0;
            r.kind  = TK_NAME;
         end
      endcase
      return r;
   endfunction

   function automatic token_kind_type op_single(input held_op_type op);
      token_kind_type r;
      unique case (op)
         OP_LT:    r = TK_LT;
         OP_GT:    r = TK_GT;
         OP_MINUS: r = TK_MINUS;
         OP_STAR:  r = TK_STAR;
         OP_SLASH: r = TK_SLASH;
         OP_AMP:   r = TK_AMP;
         OP_BAR:   r = TK_BAR;
         OP_EQ:    r = TK_ASSIGN;
         OP_DOT:   r = TK_DOT;
         default:  r = TK_NAME;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] op_second(input held_op_type op);
      logic [7:0] r;
      unique case (op)
         OP_LT:    r = 8'h3D;
         OP_GT:    r = 8'h3D;
         OP_MINUS: r = 8'h3E;
         OP_STAR:  r = 8'h2F;
         OP_SLASH: r = 8'h2A;
         OP_AMP:   r = 8'h26;
         OP_BAR:   r = 8'h7C;
         OP_EQ:    r = 8'h3D;
         OP_DOT:   r = 8'h2E;
         default:  r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic token_kind_type op_double(input held_op_type op);
      token_kind_type r;
      unique case (op)
         OP_LT:    r = TK_LE;
         OP_GT:    r = TK_GE;
         OP_MINUS: r = TK_ARROW;
         OP_STAR:  r = TK_COMMENT_CLOSE;
         OP_SLASH: r = TK_COMMENT_OPEN;
         OP_AMP:   r = TK_ANDAND;
         OP_BAR:   r = TK_OROR;
         OP_EQ:    r = TK_EQ;
         OP_DOT:   r = TK_DOTDOT;
         default:  r = TK_NAME;
      endcase
      return r;
   endfunction

   // All six keyword compares run in parallel on the held prefix.
   function automatic token_kind_type name_kind(input logic [2:0] len,
                                                input logic [47:0] prefix);
      token_kind_type r;
      priority if (len == 3'd3 && prefix == KW_FUN)    r = TK_FUN;
      else if     (len == 3'd6 && prefix == KW_STRUCT) r = TK_STRUCT;
      else if     (len == 3'd6 && prefix == KW_UNSAVE) r = TK_UNSAVE;
      else if     (len == 3'd5 && prefix == KW_WHERE)  r = TK_WHERE;
      else if     (len == 3'd4 && prefix == KW_ENUM)   r = TK_ENUM;
      else if     (len == 3'd5 && prefix == KW_PRINT)  r = TK_PRINT;
      else                                             r = TK_NAME;
      return r;
   endfunction

   pos_type     pos_ff, pos_in;
   held_op_type held_ff, held_in;
   pos_type     held_pos_ff, held_pos_in;
   logic [2:0]  name_len_ff, name_len_in;
   logic [47:0] prefix_ff, prefix_in;
   pos_type     name_start_ff, name_start_in;

   logic        accept;
   logic [7:0]  c;
   logic        held_v, name_v, c_sep, ordinary, consumed;
   held_op_type c_op;
   punct_type   c_pk;
   token_type   held_tok, name_tok, punct_tok, slot0, slot1;
   logic        slot0_v, slot1_v;

   // Room for two more tokens is required before a transaction is taken.
   assign req_stall = q_stat.count > qcnt_type'(QUEUE_DEPTH - 2);
   assign accept    = req_valid && !req_stall;

   // Classify the byte and build the up to two tokens it releases.
   always_comb begin
      c        = req_source_byte;
      held_v   = held_ff != OP_NONE;
      name_v   = name_len_ff != 3'd0;
      c_op     = op_of(c);
      c_pk     = punct_of(c);
      c_sep    = (c == CH_SPACE) || (c == CH_CR) || (c == CH_TAB);
      ordinary = !c_sep && !c_pk.valid && (c_op == OP_NONE);
      consumed = !req_end_of_text && held_v && (c == op_second(held_ff));

      held_tok.kind      = consumed ? op_double(held_ff) : op_single(held_ff);
      held_tok.first_pos = out_pos_type'(held_pos_ff);
      held_tok.final_pos = consumed ? out_pos_type'(held_pos_ff + pos_type'(1))
                                    : out_pos_type'(held_pos_ff);
      held_tok.last      = 1'b0;

      name_tok.kind      = name_kind(name_len_ff, prefix_ff);
      name_tok.first_pos = out_pos_type'(name_start_ff);
      name_tok.final_pos = out_pos_type'(pos_ff - pos_type'(1));
      name_tok.last      = 1'b0;

      punct_tok.kind      = c_pk.kind;
      punct_tok.first_pos = out_pos_type'(pos_ff);
      punct_tok.final_pos = out_pos_type'(pos_ff);
      punct_tok.last      = 1'b0;

      slot0 = held_v ? held_tok : name_tok;
      slot1 = punct_tok;
      if (req_end_of_text) begin
         slot0_v = held_v || name_v;
         slot1_v = 1'b0;
      end else begin
         slot0_v = held_v || (name_v && !ordinary);
         slot1_v = !consumed && c_pk.valid;
      end
   end

   // Compact the tokens into the push transaction and mark the last one.
   always_comb begin
      push.count     = accept ? (2'(slot0_v) + 2'(slot1_v)) : 2'd0;
      push.tok0      = slot0_v ? slot0 : slot1;
      push.tok0.last = !(slot0_v && slot1_v);
      push.tok1      = slot1;
      push.tok1.last = 1'b1;
   end

   // Next state of position, lookahead and pending name.
   always_comb begin
      pos_in        = pos_ff;
      held_in       = held_ff;
      held_pos_in   = held_pos_ff;
      name_len_in   = name_len_ff;
      prefix_in     = prefix_ff;
      name_start_in = name_start_ff;
      if (accept) begin
         if (req_end_of_text) begin
            held_in     = OP_NONE;
            name_len_in = 3'd0;
            prefix_in   = '0;
         end else begin
            pos_in  = pos_ff + pos_type'(1);
            held_in = OP_NONE;
            if (!consumed && c_op != OP_NONE) begin
               held_in     = c_op;
               held_pos_in = pos_ff;
            end
            if (!consumed && ordinary) begin
               if (!name_v) begin
                  name_start_in = pos_ff;
                  prefix_in     = 48'(c);
               end else if (name_len_ff < NAME_KEEP) begin
                  prefix_in = prefix_ff | (48'(c) << {name_len_ff, 3'b000});
               end
               name_len_in = (name_len_ff == NAME_SAT) ? NAME_SAT : name_len_ff + 3'd1;
            end else if (!consumed && name_v) begin
               name_len_in = 3'd0;
               prefix_in   = '0;
            end
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         held_ff     <= OP_NONE;
         name_len_ff <= 3'd0;
      end else begin
         pos_ff      <= pos_in;
         held_ff     <= held_in;
         name_len_ff <= name_len_in;
      end
   end

   // Payload state, only read while its valid marker is set.
   always_ff @(posedge clock) begin
      held_pos_ff   <= held_pos_in;
      prefix_ff     <= prefix_in;
      name_start_ff <= name_start_in;
   end

endmodule

@@ sv/stt_token_queue.sv @@
// Token queue between classifier and output stage: two writes, one read per cycle.
// Depends on stt_pkg; written by stt_front, drained by stt_back.
module stt_token_queue (
   input  logic                clock,
   input  logic                reset,
   input  stt_pkg::push_type   push,
   input  logic                pop,
   output stt_pkg::token_type  head,
   output stt_pkg::qstat_type  q_stat
);
   import stt_pkg::*;

   function automatic qptr_type ptr_next(input qptr_type p);
      return (p == qptr_type'(QUEUE_DEPTH - 1)) ? '0 : p + qptr_type'(1);
   endfunction

   token_type tok_ff [QUEUE_DEPTH];
   qptr_type  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   qcnt_type  count_ff, count_in;
   qptr_type  wr_second;

   assign wr_second       = ptr_next(wr_ptr_ff);
   assign head            = tok_ff[rd_ptr_ff];
   assign q_stat.count    = count_ff;
   assign q_stat.not_empty = count_ff != '0;

   // Pointer and fill count updates.
   always_comb begin
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      unique case (push.count)
         2'd1:    wr_ptr_in = wr_second;
         2'd2:    wr_ptr_in = ptr_next(wr_second);
         default: wr_ptr_in = wr_ptr_ff;
      endcase
      count_in = count_ff + qcnt_type'(push.count) - qcnt_type'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Token storage.
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         tok_ff[wr_ptr_ff] <= push.tok0;
      end
      if (push.count == 2'd2) begin
         tok_ff[wr_second] <= push.tok1;
      end
   end

endmodule

@@ sv/stt_back.sv @@
// Output stage of the tokenizer: registers one token and presents it on the result port.
// Depends on stt_pkg; drains stt_token_queue.
module stt_back (
   input  logic                       clock,
   input  logic                       reset,
   input  stt_pkg::token_type         head,
   input  stt_pkg::qstat_type         q_stat,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [5:0]                 rsp_token_kind,
   output logic [stt_pkg::OUT_POS_BITS-1:0] rsp_first_pos,
   output logic [stt_pkg::OUT_POS_BITS-1:0] rsp_final_pos,
   output logic                       rsp_last_of_run
);
   import stt_pkg::*;

   logic      out_valid_ff, out_valid_in;
   token_type out_tok_ff;

   // Load a new token when the register is empty or its token is being taken.
   assign pop          = q_stat.not_empty && (!out_valid_ff || !rsp_stall);
   assign out_valid_in = pop || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_tok_ff <= head;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_token_kind  = out_tok_ff.kind;
   assign rsp_first_pos   = out_tok_ff.first_pos;
   assign rsp_final_pos   = out_tok_ff.final_pos;
   assign rsp_last_of_run = out_tok_ff.last;

endmodule
